@@ design/sst_pkg.sv @@
// Shared types, token kinds, character codes and keyword table of the source tokenizer.
package sst_pkg;

	// One source byte as it arrives on the input channel.
	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} src_item_t;

	// One token as it leaves on the output channel.
	typedef struct packed {
		logic [5:0]  token_kind;
		logic [23:0] start_offset;
		logic [23:0] end_offset;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic        lex_error;
		logic        final_token;
	} tok_item_t;

	// Up to four tokens produced by one source byte, handed from lexer to queue.
	typedef struct packed {
		logic                 push;
		logic [2:0]           cnt;
		tok_item_t [3:0]      item;
	} tok_burst_t;

	// Lexer modes.
	typedef enum logic [3:0] {
		M_BOM0,
		M_BOM1,
		M_BOM2,
		M_IDLE,
		M_COMMENT,
		M_SLASH,
		M_NBSP,
		M_INT,
		M_DOT,
		M_FRAC,
		M_WORD,
		M_OP,
		M_STR,
		M_ESC
	} lex_mode_t;

	// Token kinds that the lexer names directly.
	localparam logic [5:0] KD_IDENT   = 6'd0;
	localparam logic [5:0] KD_NUMBER  = 6'd1;
	localparam logic [5:0] KD_STRING  = 6'd2;
	localparam logic [5:0] KD_KW_BASE = 6'd3;
	localparam logic [5:0] KD_DIV     = 6'd36;
	localparam logic [5:0] KD_DIV_SET = 6'd37;
	localparam logic [5:0] KD_DOT     = 6'd62;
	localparam logic [6:0] KIND_NONE  = 7'd64;

	// Character codes.
	localparam logic [7:0] CH_BOM0   = 8'hEF;
	localparam logic [7:0] CH_BOM1   = 8'hBB;
	localparam logic [7:0] CH_BOM2   = 8'hBF;
	localparam logic [7:0] CH_NBSP0  = 8'hC2;
	localparam logic [7:0] CH_NBSP1  = 8'hA0;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	// Keywords, each padded with spaces to seven characters.
	localparam int KW_COUNT = 25;
	localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
		"and    ", "break  ", "case   ", "catch  ", "default", "switch ", "struct ",
		"else   ", "false  ", "fn     ", "for    ", "foreach", "if     ", "in     ",
		"is     ", "null   ", "or     ", "print  ", "println", "return ", "true   ",
		"try    ", "using  ", "var    ", "while  "
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd5, 3'd4, 3'd5, 3'd7, 3'd6, 3'd6, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd2,
		3'd2, 3'd2, 3'd4, 3'd2, 3'd5, 3'd7, 3'd6, 3'd4, 3'd3, 3'd5, 3'd3, 3'd5
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
	endfunction

	// Single-character tokens that never pair with a following byte.
	function automatic logic [6:0] lone_kind(input logic [7:0] c);
		logic [6:0] k;
		unique case (c)
			8'h5E:   k = 7'd52;
			8'h7E:   k = 7'd53;
			8'h28:   k = 7'd54;
			8'h29:   k = 7'd55;
			8'h7B:   k = 7'd56;
			8'h7D:   k = 7'd57;
			8'h5B:   k = 7'd58;
			8'h5D:   k = 7'd59;
			8'h3B:   k = 7'd60;
			8'h2C:   k = 7'd61;
			8'h2E:   k = 7'd62;
			8'h3A:   k = 7'd63;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	// Operators that may be the first of two characters.
	function automatic logic [6:0] lead_kind(input logic [7:0] c);
		logic [6:0] k;
		unique case (c)
			8'h2B:   k = 7'd28;
			8'h2D:   k = 7'd31;
			8'h2A:   k = 7'd34;
			8'h25:   k = 7'd38;
			8'h3D:   k = 7'd40;
			8'h21:   k = 7'd42;
			8'h3C:   k = 7'd44;
			8'h3E:   k = 7'd47;
			8'h26:   k = 7'd50;
			8'h7C:   k = 7'd51;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	// Two-character operators; the logical and/or share the keyword kinds.
	function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
		logic [6:0] k;
		k = KIND_NONE;
		unique case (h)
			8'h2B: begin
				if (c == 8'h2B) k = 7'd29;
				else if (c == CH_EQ) k = 7'd30;
			end
			8'h2D: begin
				if (c == 8'h2D) k = 7'd32;
				else if (c == CH_EQ) k = 7'd33;
			end
			8'h2A: if (c == CH_EQ) k = 7'd35;
			8'h25: if (c == CH_EQ) k = 7'd39;
			8'h3D: if (c == CH_EQ) k = 7'd41;
			8'h21: if (c == CH_EQ) k = 7'd43;
			8'h3C: begin
				if (c == CH_EQ) k = 7'd45;
				else if (c == 8'h3C) k = 7'd46;
			end
			8'h3E: begin
				if (c == CH_EQ) k = 7'd48;
				else if (c == 8'h3E) k = 7'd49;
			end
			8'h26: if (c == 8'h26) k = 7'd3;
			8'h7C: if (c == 8'h7C) k = 7'd19;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

@@ design/script_source_tokenizer.sv @@
// Top level of the script source tokenizer: lexer front end and token queue.
//
// Source bytes enter on the src channel, one byte per beat, with end_of_source
// set on the last byte of a source. Tokens leave on the tok channel, one per
// beat, in source order. Each byte yields zero to four tokens; the last byte
// of a source always ends with a token that has final_token set, after which
// the lexer is back in its reset state and the next byte starts a new source.
//
// The lexer step is combinational; the tokens a byte completes are written to
// the queue as the byte is taken. Throughput: one source byte per cycle while
// src_ready is high; tokens drain at one per cycle, while tok_ready is high,
// from an eight-entry queue. A byte is taken only while the queue holds four
// or fewer tokens, so a byte whose burst cannot fit waits on src_ready.
//
// Reset clears the lexer state and empties the queue. When the receiver
// stalls, tokens collect in the queue and src_ready drops once the queue
// cannot hold another full burst; nothing is lost or repeated.
module script_source_tokenizer import sst_pkg::*; #(
	parameter int PREFIX_BYTES = 8,
	parameter int OFFSET_BITS  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_item_t src_data,
	output logic      tok_valid,
	input  logic      tok_ready,
	output tok_item_t tok_data
);

	tok_burst_t burst;
	logic       room;

	assign src_ready = room;

	// Lexer front end.
	sst_front #(
		.PREFIX_BYTES(PREFIX_BYTES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(src_valid && room),
		.src   (src_data),
		.burst (burst)
	);

	// Token queue and output side.
	sst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (burst),
		.room     (room),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_data (tok_data)
	);

endmodule

@@ design/sst_front.sv @@
// Lexer front end: takes one source byte per beat and produces up to four tokens.
module sst_front import sst_pkg::*; #(
	parameter int PREFIX_BYTES = 8,
	parameter int OFFSET_BITS  = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  src_item_t  src,
	output tok_burst_t burst
);

	localparam int LW = $clog2(PREFIX_BYTES + 2);
	localparam int IW = $clog2(PREFIX_BYTES);
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	typedef logic [PREFIX_BYTES-1:0][7:0] prefix_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_item_t  t0;
		tok_item_t  t1;
	} flush_t;

	lex_mode_t              mode_q;
	logic [7:0]             held_q;
	logic [7:0]             quote_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [15:0]            line_q;
	logic [15:0]            col_q;
	logic [OFFSET_BITS-1:0] tb_q;
	logic [15:0]            tbc_q;
	prefix_t                wp_q;
	logic [LW-1:0]          wl_q;

	lex_mode_t              md;
	logic [7:0]             hb;
	logic [7:0]             qc;
	logic [OFFSET_BITS-1:0] off;
	logic [15:0]            ln;
	logic [15:0]            col;
	logic [OFFSET_BITS-1:0] tb;
	logic [15:0]            tbc;
	prefix_t                wp;
	logic [LW-1:0]          wl;
	logic [2:0]             n;
	tok_item_t [3:0]        tok;
	logic                   do_feed;
	logic                   fi;
	logic                   idle;
	logic [6:0]             k;
	flush_t                 fl;
	logic [7:0]             c;

	function automatic tok_item_t mk(input logic [5:0] kind, input logic [OFFSET_BITS-1:0] s,
			input logic [OFFSET_BITS-1:0] e, input logic [15:0] line, input logic [15:0] column,
			input logic err, input logic fin);
		tok_item_t t;
		t.token_kind   = kind;
		t.start_offset = 24'(s);
		t.end_offset   = 24'(e);
		t.token_line   = line;
		t.token_column = column;
		t.lex_error    = err;
		t.final_token  = fin;
		return t;
	endfunction

	// Keyword lookup over the prefix buffer; anything else is an identifier.
	function automatic logic [5:0] word_kind(input prefix_t p, input logic [LW-1:0] len);
		logic [5:0] kind;
		logic       hit;
		kind = KD_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (len == LW'(KW_LEN[i]));
			for (int j = 0; j < 7; j++) begin
				if ((j < int'(KW_LEN[i])) && (p[j] != KW_TEXT[i][55 - 8*j -: 8]))
					hit = 1'b0;
			end
			if (hit)
				kind = 6'(int'(KD_KW_BASE) + i);
		end
		return kind;
	endfunction

	// Closes whatever token is pending; a held dot gives a number and a dot.
	function automatic flush_t flush(input lex_mode_t m, input logic [7:0] h,
			input logic [OFFSET_BITS-1:0] o, input logic [15:0] line, input logic [15:0] column,
			input logic [OFFSET_BITS-1:0] b, input logic [15:0] bc, input logic [5:0] wk);
		flush_t                 f;
		logic [OFFSET_BITS-1:0] held;
		logic [6:0]             lk;
		f.cnt = 2'd1;
		f.t1  = mk(KD_DOT, o, o, line, column, 1'b0, 1'b0);
		held  = (o != '0) ? o - 1'b1 : '0;
		lk    = lead_kind(h);
		unique case (m)
			M_SLASH: f.t0 = mk(KD_DIV, b, o, line, bc, 1'b0, 1'b0);
			M_NBSP:  f.t0 = mk(KD_IDENT, b, o, line, bc, 1'b1, 1'b0);
			M_INT, M_FRAC: f.t0 = mk(KD_NUMBER, b, o, line, bc, 1'b0, 1'b0);
			M_DOT: begin
				f.cnt = 2'd2;
				f.t0  = mk(KD_NUMBER, b, held, line, bc, 1'b0, 1'b0);
				f.t1  = mk(KD_DOT, held, o, line, column - 16'd1, 1'b0, 1'b0);
			end
			M_WORD: f.t0 = mk(wk, b, o, line, bc, 1'b0, 1'b0);
			M_OP:   f.t0 = mk(lk[5:0], b, o, line, bc, 1'b0, 1'b0);
			M_STR, M_ESC: f.t0 = mk(KD_STRING, b, o, line, bc, 1'b1, 1'b0);
			default: begin
				f.cnt = 2'd0;
				f.t0  = mk(KD_IDENT, b, o, line, bc, 1'b0, 1'b0);
			end
		endcase
		return f;
	endfunction

	// One complete lexer step for the byte at the input.
	always_comb begin
		md  = mode_q;
		hb  = held_q;
		qc  = quote_q;
		off = off_q;
		ln  = line_q;
		col = col_q;
		tb  = tb_q;
		tbc = tbc_q;
		wp  = wp_q;
		wl  = wl_q;
		n   = 3'd0;
		tok = '0;
		c   = src.source_byte;
		do_feed = 1'b1;
		fi   = 1'b0;
		idle = 1'b0;
		k    = KIND_NONE;

		// Byte-order mark check; a broken mark gives its bytes back as unknowns.
		unique case (mode_q)
			M_BOM0: begin
				if (c == CH_BOM0) begin
					md = M_BOM1;
					do_feed = 1'b0;
				end else begin
					md = M_IDLE;
				end
			end
			M_BOM1: begin
				md = M_IDLE;
				if (c == CH_BOM1) begin
					md = M_BOM2;
					do_feed = 1'b0;
				end else begin
					tok[n[1:0]] = mk(KD_IDENT, off, off + 1'b1, ln, col, 1'b1, 1'b0);
					n = n + 3'd1;
					tb = off;
					tbc = col;
					off = off + 1'b1;
					col = col + 16'd1;
				end
			end
			M_BOM2: begin
				md = M_IDLE;
				if (c == CH_BOM2) begin
					off = OFFSET_BITS'(3);
					do_feed = 1'b0;
				end else begin
					tok[n[1:0]] = mk(KD_IDENT, off, off + 1'b1, ln, col, 1'b1, 1'b0);
					n = n + 3'd1;
					off = off + 1'b1;
					col = col + 16'd1;
					tok[n[1:0]] = mk(KD_IDENT, off, off + 1'b1, ln, col, 1'b1, 1'b0);
					n = n + 3'd1;
					tb = off;
					tbc = col;
					off = off + 1'b1;
					col = col + 16'd1;
				end
			end
			default: ;
		endcase

		// Continue or end the pending token.
		if (do_feed) begin
			unique case (md)
				M_COMMENT: begin
					if (c == CH_LF) begin
						md = M_IDLE;
						if (off != OFF_MAX) off = off + 1'b1;
						ln = ln + 16'd1;
						col = 16'd1;
					end else begin
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end
				end
				M_SLASH: begin
					if (c == CH_SLASH) begin
						md = M_COMMENT;
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end else if (c == CH_EQ) begin
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
						tok[n[1:0]] = mk(KD_DIV_SET, tb, off, ln, tbc, 1'b0, 1'b0);
						n = n + 3'd1;
						md = M_IDLE;
					end else begin
						fi = 1'b1;
					end
				end
				M_NBSP: begin
					if (c == CH_NBSP1) begin
						md = M_IDLE;
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end else begin
						fi = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end else if (c == CH_PERIOD) begin
						md = M_DOT;
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end else begin
						fi = 1'b1;
					end
				end
				M_DOT, M_FRAC: begin
					if (is_digit(c)) begin
						md = M_FRAC;
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end else begin
						fi = 1'b1;
					end
				end
				M_WORD: begin
					if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) begin
						if (wl < LW'(PREFIX_BYTES)) wp[wl[IW-1:0]] = c;
						if (wl <= LW'(PREFIX_BYTES)) wl = wl + 1'b1;
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end else begin
						fi = 1'b1;
					end
				end
				M_OP: begin
					k = pair_kind(hb, c);
					if (k != KIND_NONE) begin
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
						tok[n[1:0]] = mk(k[5:0], tb, off, ln, tbc, 1'b0, 1'b0);
						n = n + 3'd1;
						md = M_IDLE;
					end else begin
						fi = 1'b1;
					end
				end
				M_STR: begin
					if (c == qc) begin
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
						tok[n[1:0]] = mk(KD_STRING, tb, off, ln, tbc, 1'b0, 1'b0);
						n = n + 3'd1;
						md = M_IDLE;
					end else if (c == CH_LF) begin
						if (off != OFF_MAX) off = off + 1'b1;
						ln = ln + 16'd1;
						col = 16'd1;
					end else begin
						if (c == CH_BSLASH) md = M_ESC;
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end
				end
				M_ESC: begin
					md = M_STR;
					if (c == CH_LF) begin
						if (off != OFF_MAX) off = off + 1'b1;
						ln = ln + 16'd1;
						col = 16'd1;
					end else begin
						if (off != OFF_MAX) off = off + 1'b1;
						col = col + 16'd1;
					end
				end
				default: begin
					md = M_IDLE;
					idle = 1'b1;
				end
			endcase

			// A byte that does not extend the pending token closes it first.
			if (fi) begin
				fl = flush(md, hb, off, ln, col, tb, tbc, word_kind(wp_q, wl_q));
				if (fl.cnt != 2'd0) begin
					tok[n[1:0]] = fl.t0;
					n = n + 3'd1;
				end
				if (fl.cnt == 2'd2) begin
					tok[n[1:0]] = fl.t1;
					n = n + 3'd1;
				end
				md = M_IDLE;
				idle = 1'b1;
			end

			// Start of a new token, or skipped whitespace.
			if (idle) begin
				if (is_blank(c)) begin
					if (off != OFF_MAX) off = off + 1'b1;
					col = col + 16'd1;
				end else if (c == CH_LF) begin
					if (off != OFF_MAX) off = off + 1'b1;
					ln = ln + 16'd1;
					col = 16'd1;
				end else begin
					tb = off;
					tbc = col;
					k = lead_kind(c);
					if (c == CH_SLASH) begin
						md = M_SLASH;
					end else if (c == CH_NBSP0) begin
						md = M_NBSP;
					end else if (is_digit(c)) begin
						md = M_INT;
					end else if (is_alpha(c) || (c == CH_UNDER)) begin
						wp[0] = c;
						wl = LW'(1);
						md = M_WORD;
					end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
						qc = c;
						md = M_STR;
					end else if (k != KIND_NONE) begin
						hb = c;
						md = M_OP;
					end
					if (off != OFF_MAX) off = off + 1'b1;
					col = col + 16'd1;
					if (md == M_IDLE) begin
						k = lone_kind(c);
						if (k == KIND_NONE)
							tok[n[1:0]] = mk(KD_IDENT, tb, off, ln, tbc, 1'b1, 1'b0);
						else
							tok[n[1:0]] = mk(k[5:0], tb, off, ln, tbc, 1'b0, 1'b0);
						n = n + 3'd1;
					end
				end
			end
		end

		// End of source: give back a partial mark, close the token, add the end token.
		fl = flush(md, hb, off, ln, col, tb, tbc, word_kind(wp, wl));
		if (src.end_of_source) begin
			if ((md == M_BOM1) || (md == M_BOM2)) begin
				tok[n[1:0]] = mk(KD_IDENT, off, off + 1'b1, ln, col, 1'b1, 1'b0);
				n = n + 3'd1;
				off = off + 1'b1;
				col = col + 16'd1;
				if (md == M_BOM2) begin
					tok[n[1:0]] = mk(KD_IDENT, off, off + 1'b1, ln, col, 1'b1, 1'b0);
					n = n + 3'd1;
					off = off + 1'b1;
					col = col + 16'd1;
				end
			end else begin
				if (fl.cnt != 2'd0) begin
					tok[n[1:0]] = fl.t0;
					n = n + 3'd1;
				end
				if (fl.cnt == 2'd2) begin
					tok[n[1:0]] = fl.t1;
					n = n + 3'd1;
				end
			end
			tok[n[1:0]] = mk(KD_IDENT, off, off, ln, col, 1'b0, 1'b1);
			n = n + 3'd1;
			md  = M_BOM0;
			hb  = '0;
			qc  = '0;
			off = '0;
			ln  = 16'd1;
			col = 16'd1;
			tb  = '0;
			tbc = 16'd1;
			wl  = '0;
		end

		burst.push = accept;
		burst.cnt  = n;
		burst.item = tok;
	end

	// Lexer state advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_BOM0;
			held_q  <= '0;
			quote_q <= '0;
			off_q   <= '0;
			line_q  <= 16'd1;
			col_q   <= 16'd1;
			tb_q    <= '0;
			tbc_q   <= 16'd1;
			wl_q    <= '0;
		end else if (accept) begin
			mode_q  <= md;
			held_q  <= hb;
			quote_q <= qc;
			off_q   <= off;
			line_q  <= ln;
			col_q   <= col;
			tb_q    <= tb;
			tbc_q   <= tbc;
			wl_q    <= wl;
		end
	end

	// Word prefix bytes are only read after being written.
	always_ff @(posedge clk) begin
		if (accept) begin
			wp_q <= wp;
		end
	end

endmodule

@@ design/sst_queue.sv @@
// Token queue: takes bursts of up to four tokens and delivers one token per beat.
module sst_queue import sst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tok_burst_t burst,
	output logic       room,
	output logic       tok_valid,
	input  logic       tok_ready,
	output tok_item_t  tok_data
);

	localparam int DEPTH = 8;
	localparam int AW    = $clog2(DEPTH);

	tok_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     count_q;
	logic            pop;
	logic [AW:0]     add;

	// Space for a whole burst is needed before a source byte is taken.
	assign room      = (count_q <= (AW+1)'(DEPTH - 4));
	assign tok_valid = (count_q != '0);
	assign tok_data  = mem_q[rd_q];
	assign pop       = tok_valid && tok_ready;
	assign add       = burst.push ? (AW+1)'(burst.cnt) : '0;

	// Entry storage.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (burst.push && (i < int'(burst.cnt)))
				mem_q[wr_q + AW'(i)] <= burst.item[i];
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(add);
			rd_q    <= rd_q + AW'(pop);
			count_q <= count_q + add - (AW+1)'(pop);
		end
	end

endmodule
